// ----- rtl/ash_pkg.sv -----
// Package for the haversine angular separation pipeline.
// Holds widths, CORDIC and root stage types, the arctangent table and step functions.
// No dependencies.
package ash_pkg;

  localparam int ANGLE_BITS   = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int ROOT_STEPS   = 32;
  localparam int SH           = 32 - ANGLE_BITS;

  // input reg + rotators + two product stages + first root
  // + r*r stage + second root + vectoring + output reg
  localparam int PIPE_DEPTH = 2 * (CORDIC_STEPS + 1) + 2 + 2 * (ROOT_STEPS + 1) + 1 + 1;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE  = 34'sd1073741824;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cord_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } root_t;

  function automatic logic signed [33:0] atan_unit(input int i);
    logic signed [33:0] v;
    case (i)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933405;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335086;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41721;
      15: v = 34'sd20860;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2607;
      19: v = 34'sd1303;
      20: v = 34'sd651;
      21: v = 34'sd325;
      22: v = 34'sd162;
      23: v = 34'sd81;
      24: v = 34'sd40;
      25: v = 34'sd20;
      26: v = 34'sd10;
      27: v = 34'sd5;
      28: v = 34'sd2;
      29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // rotation mode: drive z toward zero
  function automatic cord_t cordic_rot(input cord_t c, input int i);
    cord_t o;
    logic signed [33:0] dx, dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.z >= 0) begin
      o.x = c.x - dx; o.y = c.y + dy; o.z = c.z - atan_unit(i);
    end else begin
      o.x = c.x + dx; o.y = c.y - dy; o.z = c.z + atan_unit(i);
    end
    return o;
  endfunction

  // vectoring mode: drive y toward zero, accumulate angle in z
  function automatic cord_t cordic_vec(input cord_t c, input int i);
    cord_t o;
    logic signed [33:0] dx, dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y >= 0) begin
      o.x = c.x + dx; o.y = c.y - dy; o.z = c.z + atan_unit(i);
    end else begin
      o.x = c.x - dx; o.y = c.y + dy; o.z = c.z - atan_unit(i);
    end
    return o;
  endfunction

  function automatic root_t root_step(input root_t r, input int k);
    root_t o;
    logic [63:0] bitv, trial;
    bitv  = 64'd1 << (62 - 2 * k);
    trial = r.res + bitv;
    if (r.n >= trial) begin
      o.n   = r.n - trial;
      o.res = (r.res >> 1) + bitv;
    end else begin
      o.n   = r.n;
      o.res = r.res >> 1;
    end
    return o;
  endfunction

  // fold angle into [-quarter, quarter) for the rotator, report flip
  function automatic cord_t fold_angle(input logic [31:0] a, output logic flip);
    cord_t o;
    logic [31:0] t, a2;
    t    = a + 32'h4000_0000;
    flip = t[31];
    a2   = flip ? (a + 32'h8000_0000) : a;
    o.x  = GAIN_Q30;
    o.y  = '0;
    o.z  = 34'($signed(a2));
    return o;
  endfunction

endpackage

// ----- rtl/angular_separation_haversine.sv -----
// Top level: great-circle separation of two sky points by the haversine formula.
// Depends on ash_pkg (types, CORDIC and root step functions).
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+----------------------------
//  input    | start, busy, in_start_ra/dec, in_end_* | start high and busy low
//  result   | out_valid, out_separation               | out_valid high, one cycle
//
// One item enters every cycle; each passes through four parallel rotators, two
// 32-step bitwise roots and the vectoring CORDIC, one step per stage.
// busy stays low: the pipeline never holds, since results cannot be stalled.
// Synchronous reset clears the valid bits only; data stages run freely.
module angular_separation_haversine import ash_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [ANGLE_BITS-1:0] in_start_ra,
  input  logic [ANGLE_BITS-1:0] in_start_dec,
  input  logic [ANGLE_BITS-1:0] in_end_ra,
  input  logic [ANGLE_BITS-1:0] in_end_dec,
  output logic                  out_valid,
  output logic [ANGLE_BITS-1:0] out_separation
);

  localparam logic [33:0] HALF_C = (SH > 0) ? (34'd1 << (SH - 1)) : 34'd0;
  localparam logic [33:0] LIMIT_C = 34'd1 << (ANGLE_BITS - 1);

  logic [PIPE_DEPTH-1:0] vld_r;

  cord_t cr_r [4][CORDIC_STEPS+1];
  logic  fl_r [4][CORDIC_STEPS+1];

  logic [31:0]        hra_r, hdec_r, hdec_b_r;
  logic signed [33:0] cc_r;
  logic signed [66:0] pm_r;

  root_t              rt1_r [ROOT_STEPS+1];
  logic [30:0]        r_d_r;
  logic [61:0]        rr_d_r;
  root_t              rt2_r [ROOT_STEPS+1];
  logic [30:0]        r2_r  [ROOT_STEPS+1];
  cord_t              av_r  [CORDIC_STEPS+1];
  logic [ANGLE_BITS-1:0] sep_r;

  logic [31:0] ra1, dec1, ra2, dec2, dra, ddec;
  cord_t       f0, f1, f2, f3;
  logic        g0, g1, g2, g3;
  logic signed [33:0] sv0, sv1, cv2, cv3;
  logic [31:0] sa0, sa1;
  logic signed [63:0] ccp;
  logic [63:0] h0p, h1p;
  logic signed [39:0] aux;
  logic signed [39:0] aux_sat;
  logic [63:0] r1res;
  logic [30:0] rcl;
  logic signed [33:0] zf;
  logic [33:0] zc, sep34, seps;

  assign busy = 1'b0;

  always_comb begin
    ra1  = 32'(in_start_ra)  << SH;
    dec1 = 32'(in_start_dec) << SH;
    ra2  = 32'(in_end_ra)    << SH;
    dec2 = 32'(in_end_dec)   << SH;
    dra  = (ra1 - ra2) >> 1;
    ddec = (dec1 - dec2) >> 1;
    f0 = fold_angle(dra, g0);
    f1 = fold_angle(ddec, g1);
    f2 = fold_angle(dec1, g2);
    f3 = fold_angle(dec2, g3);

    // undo the half-turn fold
    sv0 = fl_r[0][CORDIC_STEPS] ? -cr_r[0][CORDIC_STEPS].y : cr_r[0][CORDIC_STEPS].y;
    sv1 = fl_r[1][CORDIC_STEPS] ? -cr_r[1][CORDIC_STEPS].y : cr_r[1][CORDIC_STEPS].y;
    cv2 = fl_r[2][CORDIC_STEPS] ? -cr_r[2][CORDIC_STEPS].x : cr_r[2][CORDIC_STEPS].x;
    cv3 = fl_r[3][CORDIC_STEPS] ? -cr_r[3][CORDIC_STEPS].x : cr_r[3][CORDIC_STEPS].x;
    sa0 = (sv0 < 0) ? 32'(-sv0) : 32'(sv0);
    sa1 = (sv1 < 0) ? 32'(-sv1) : 32'(sv1);
    h0p = 64'(sa0) * 64'(sa0);
    h1p = 64'(sa1) * 64'(sa1);
    ccp = $signed(cv2[31:0]) * $signed(cv3[31:0]);

    aux = $signed({8'd0, hdec_b_r}) + 40'(pm_r >>> 30);
    if (aux < 0) aux_sat = '0;
    else if (aux > 40'(Q30_ONE)) aux_sat = 40'(Q30_ONE);
    else aux_sat = aux;

    r1res = rt1_r[ROOT_STEPS].res;
    rcl = (r1res > 64'(Q30_ONE)) ? 31'(Q30_ONE) : r1res[30:0];

    // clamp to a quarter turn, double, round to output resolution
    zf = av_r[CORDIC_STEPS].z;
    if (zf < 0) zc = '0;
    else if (zf > Q30_ONE) zc = 34'(Q30_ONE);
    else zc = zf;
    sep34 = (zc << 1) + HALF_C;
    seps  = sep34 >> SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    cr_r[0][0] <= f0; fl_r[0][0] <= g0;
    cr_r[1][0] <= f1; fl_r[1][0] <= g1;
    cr_r[2][0] <= f2; fl_r[2][0] <= g2;
    cr_r[3][0] <= f3; fl_r[3][0] <= g3;
    for (int u = 0; u < 4; u++) begin
      for (int g = 0; g < CORDIC_STEPS; g++) begin
        cr_r[u][g+1] <= cordic_rot(cr_r[u][g], g);
        fl_r[u][g+1] <= fl_r[u][g];
      end
    end

    hra_r  <= h0p[61:30];
    hdec_r <= h1p[61:30];
    cc_r   <= 34'(ccp >>> 30);

    pm_r     <= cc_r * $signed({1'b0, hra_r});
    hdec_b_r <= hdec_r;

    rt1_r[0].n   <= 64'(aux_sat) << 30;
    rt1_r[0].res <= '0;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rt1_r[k+1] <= root_step(rt1_r[k], k);
    end

    r_d_r  <= rcl;
    rr_d_r <= 62'(rcl) * 62'(rcl);

    rt2_r[0].n   <= (64'd1 << 60) - 64'(rr_d_r);
    rt2_r[0].res <= '0;
    r2_r[0]      <= r_d_r;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      rt2_r[k+1] <= root_step(rt2_r[k], k);
      r2_r[k+1]  <= r2_r[k];
    end

    av_r[0].x <= 34'(rt2_r[ROOT_STEPS].res[31:0]);
    av_r[0].y <= 34'(r2_r[ROOT_STEPS]);
    av_r[0].z <= '0;
    for (int g = 0; g < CORDIC_STEPS; g++) begin
      av_r[g+1] <= cordic_vec(av_r[g], g);
    end

    sep_r <= (seps > LIMIT_C) ? LIMIT_C[ANGLE_BITS-1:0] : seps[ANGLE_BITS-1:0];
  end

  assign out_valid      = vld_r[PIPE_DEPTH-1];
  assign out_separation = sep_r;

endmodule

// ----- rtl/ash_checker.sv -----
// Port-level checker for angular_separation_haversine, attached by bind.
// Depends on ash_pkg for PIPE_DEPTH and ANGLE_BITS.
module ash_port_checker import ash_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [ANGLE_BITS-1:0] out_separation
);

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  a_no_hold: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(PIPE_DEPTH) out_valid)
    else $error("accepted item produced no result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_separation <= HALF_TURN))
    else $error("separation beyond a half turn");

endmodule

bind angular_separation_haversine ash_port_checker u_ash_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_separation (out_separation)
);
